// ===== rtl/like_wildcard_matcher_macros.svh =====
// Assertion macros used by the checker file of the LIKE matcher.
`ifndef LIKE_WILDCARD_MATCHER_MACROS_SVH
`define LIKE_WILDCARD_MATCHER_MACROS_SVH

// Same-cycle implication, masked during reset.
`define LWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define LWM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Checked at every edge, reset included.
`define LWM_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/lwm_pkg.sv =====
// Shared types, constants and the case-fold function of the LIKE matcher.
`timescale 1ns / 1ps
`default_nettype none
package lwm_pkg;

  localparam int unsigned PatternMaxDef = 64;
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [7:0] ChOne      = 8'h5F;  // '_'
  localparam logic [7:0] ChAny      = 8'h25;  // '%'
  localparam logic [7:0] ChUpperA   = 8'h41;
  localparam logic [7:0] ChUpperZ   = 8'h5A;
  localparam logic [7:0] CaseOffset = 8'h20;

  typedef enum logic {
    OP_PATTERN,
    OP_TEXT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] char_byte;
    logic       has_byte;
    logic       ends;
  } item_t;

  function automatic logic [7:0] fold_char(input logic [7:0] c, input logic ci);
    if (ci && (c >= ChUpperA) && (c <= ChUpperZ)) begin
      return c + CaseOffset;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lwm_front.sv =====
// Front end: accepts input words, classifies them and folds text bytes.
`timescale 1ns / 1ps
`default_nettype none
module lwm_front (
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic          req_type_i,
  input  wire logic [7:0]    char_byte_i,
  input  wire logic          is_last_i,
  input  wire logic          is_empty_i,
  input  wire logic          case_insensitive_i,
  input  wire logic          queue_full_i,
  output logic               push_o,
  output lwm_pkg::item_t     item_o
);
  import lwm_pkg::*;

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  always_comb begin
    item_o.op       = req_type_i ? OP_TEXT : OP_PATTERN;
    item_o.has_byte = !is_empty_i;
    item_o.ends     = is_last_i || is_empty_i;
    // pattern bytes are kept raw, the fold mode may change before the text
    item_o.char_byte = req_type_i ? fold_char(char_byte_i, case_insensitive_i) : char_byte_i;
  end

endmodule
`default_nettype wire

// ===== rtl/lwm_queue.sv =====
// Small FIFO of classified words between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module lwm_queue #(
  parameter int unsigned DEPTH = lwm_pkg::QueueDepthDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire lwm_pkg::item_t item_i,
  output logic               full_o,
  output logic               valid_o,
  input  wire logic          pop_i,
  output lwm_pkg::item_t     item_o
);
  import lwm_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  item_t           mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lwm_back.sv =====
// Back end: pattern store, position-set tracker and result register.
`timescale 1ns / 1ps
`default_nettype none
module lwm_back #(
  parameter int unsigned PATTERN_MAX = lwm_pkg::PatternMaxDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          case_insensitive_i,
  input  wire logic          item_valid_i,
  input  wire lwm_pkg::item_t item_i,
  output logic               item_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic               matched_o,
  output logic               pattern_overflow_o
);
  import lwm_pkg::*;

  localparam int unsigned LenW = $clog2(PATTERN_MAX + 1);
  localparam int unsigned IdxW = $clog2(PATTERN_MAX);
  localparam int unsigned VecW = PATTERN_MAX + 1;

  logic [7:0]      pat_q [PATTERN_MAX];
  logic [LenW-1:0] len_q, len_d, len_eff;
  logic            loading_q, loading_d;
  logic            ovf_q, ovf_d;
  logic            in_text_q, in_text_d;
  logic            lead_q, lead_d, lead_eff;
  logic [VecW-1:0] act_q, act_d;
  logic [VecW-1:0] start_q, start_d;   // closure of position zero
  logic            out_valid_q, out_valid_d;
  logic            matched_q, ovf_out_q;

  logic [VecW-1:0] any_v, adv_v, a_in, nxt, vp, carry, a_step;
  logic            produces, fire, wr_en;
  logic [IdxW-1:0] wr_addr;

  // per-position classification against the current text byte
  always_comb begin
    any_v = '0;
    adv_v = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (LenW'(i) < len_q) begin
        any_v[i] = (pat_q[i] == ChAny);
        adv_v[i] = (pat_q[i] != ChAny) &&
                   ((pat_q[i] == ChOne) ||
                    (fold_char(pat_q[i], case_insensitive_i) == item_i.char_byte));
      end
    end
  end

  // one step, then spread through runs of '%' with a carry chain
  assign a_in   = in_text_q ? act_q : start_q;
  assign nxt    = (a_in & any_v) | ((a_in & adv_v) << 1);
  assign vp     = nxt & any_v;
  assign carry  = (vp + any_v) ^ vp ^ any_v;
  assign a_step = item_i.has_byte ? (nxt | carry) : a_in;

  assign produces   = item_valid_i && (item_i.op == OP_TEXT) && item_i.ends;
  assign fire       = item_valid_i && (!produces || !out_valid_q || !out_stall_i);
  assign item_pop_o = fire;

  assign out_valid_d = (fire && produces) || (out_valid_q && out_stall_i);

  always_comb begin
    len_d     = len_q;
    loading_d = loading_q;
    ovf_d     = ovf_q;
    in_text_d = in_text_q;
    lead_d    = lead_q;
    act_d     = act_q;
    start_d   = start_q;
    wr_en     = 1'b0;
    len_eff   = loading_q ? len_q : '0;
    lead_eff  = loading_q ? lead_q : 1'b1;
    wr_addr   = len_eff[IdxW-1:0];
    if (fire) begin
      unique case (item_i.op)
        OP_PATTERN: begin
          in_text_d = 1'b0;
          len_d     = len_eff;
          lead_d    = lead_eff;
          if (!loading_q) begin
            ovf_d   = 1'b0;
            start_d = VecW'(1);
          end
          if (item_i.has_byte) begin
            if (len_eff < LenW'(PATTERN_MAX)) begin
              wr_en = 1'b1;
              len_d = len_eff + LenW'(1);
              if (lead_eff && (item_i.char_byte == ChAny)) begin
                start_d[len_d] = 1'b1;
              end else begin
                lead_d = 1'b0;
              end
            end else begin
              ovf_d = 1'b1;
            end
          end
          loading_d = !item_i.ends;
        end
        OP_TEXT: begin
          loading_d = 1'b0;
          in_text_d = !item_i.ends;
          act_d     = a_step;
        end
        default: begin
          loading_d = loading_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      loading_q   <= 1'b0;
      ovf_q       <= 1'b0;
      in_text_q   <= 1'b0;
      lead_q      <= 1'b1;
      act_q       <= VecW'(1);
      start_q     <= VecW'(1);
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      loading_q   <= loading_d;
      ovf_q       <= ovf_d;
      in_text_q   <= in_text_d;
      lead_q      <= lead_d;
      act_q       <= act_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pat_q[wr_addr] <= item_i.char_byte;
    end
    if (fire && produces) begin
      matched_q <= a_step[len_q];
      ovf_out_q <= ovf_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign matched_o          = matched_q;
  assign pattern_overflow_o = ovf_out_q;

endmodule
`default_nettype wire

// ===== rtl/like_wildcard_matcher.sv =====
// Top level of the SQL LIKE / ILIKE wildcard matcher.
//
//   channel  dir  handshake              payload
//   in       in   in_valid_i/in_stall_o  req_type_i, char_byte_i, is_last_i, is_empty_i
//   out      out  out_valid_o/out_stall_i matched_o, pattern_overflow_o
//   cfg      in   cfg_we_i               cfg_wdata_i (case_insensitive)
//
// One word per cycle sustained while the output is not stalled; the word that ends the text
// passes the queue register, then the output register, before its result leaves.
// The text step is one pass over the position vector: per-position compare plus one
// PATTERN_MAX+1 bit add that spreads matches through runs of '%'.
// Reset clears control state only; the pattern store needs no clearing pass.
// A stalled result holds the back end only on the next result word; the queue
// keeps taking words meanwhile until it fills.
`timescale 1ns / 1ps
`default_nettype none
module like_wildcard_matcher #(
  parameter int unsigned PATTERN_MAX = lwm_pkg::PatternMaxDef,
  parameter int unsigned QUEUE_DEPTH = lwm_pkg::QueueDepthDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       req_type_i,
  input  wire logic [7:0] char_byte_i,
  input  wire logic       is_last_i,
  input  wire logic       is_empty_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            matched_o,
  output logic            pattern_overflow_o,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i
);
  import lwm_pkg::*;

  logic  case_insensitive_q;
  logic  push, queue_full, queue_valid, pop;
  item_t push_item, head_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      case_insensitive_q <= 1'b0;
    end else if (cfg_we_i) begin
      case_insensitive_q <= cfg_wdata_i;
    end
  end

  lwm_front u_front (
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type_i),
    .char_byte_i        (char_byte_i),
    .is_last_i          (is_last_i),
    .is_empty_i         (is_empty_i),
    .case_insensitive_i (case_insensitive_q),
    .queue_full_i       (queue_full),
    .push_o             (push),
    .item_o             (push_item)
  );

  lwm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .pop_i   (pop),
    .item_o  (head_item)
  );

  lwm_back #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .case_insensitive_i (case_insensitive_q),
    .item_valid_i       (queue_valid),
    .item_i             (head_item),
    .item_pop_o         (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .matched_o          (matched_o),
    .pattern_overflow_o (pattern_overflow_o)
  );

endmodule
`default_nettype wire

// ===== rtl/lwm_checker.sv =====
// Port-level checker for the LIKE matcher, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "like_wildcard_matcher_macros.svh"
module lwm_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       matched_o,
  input wire logic       pattern_overflow_o
);

  // stalled result word holds
  `LWM_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(matched_o) && $stable(pattern_overflow_o), "stalled result word changed")

  // queue only fills while a result sits stalled
  `LWM_ASSERT_IMP(a_stall_cause, in_stall_o, out_valid_o, "input stalled with no result pending")

  // a free output drains the queue by at least one word
  `LWM_ASSERT_NXT(a_drain, !out_valid_o || !out_stall_i, !in_stall_o, "queue stayed full with output free")

  // both handshakes idle on the first edge out of reset
  `LWM_ASSERT_ALL(a_reset_idle, !$rose(rst_ni) || (!out_valid_o && !in_stall_o), "handshake active at reset release")

endmodule

bind like_wildcard_matcher lwm_checker u_lwm_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .matched_o          (matched_o),
  .pattern_overflow_o (pattern_overflow_o)
);
`default_nettype wire
